// ===== rtl/core/pes_pkg.sv =====
// pes_pkg: microcode types, step addresses and control store for product_except_self
// depends on nothing; used by rtl/core/product_except_self.sv
`default_nettype none

package pes_pkg;

    // result field width, fixed by the result format
    localparam int unsigned OUT_W = 32;

    typedef logic [2:0] t_pc;

    // step addresses of the control program
    localparam t_pc ST_LOAD    = 3'd0;
    localparam t_pc ST_SUF_RD  = 3'd1;
    localparam t_pc ST_SUF_MUL = 3'd2;
    localparam t_pc ST_EM_SET  = 3'd3;
    localparam t_pc ST_EM_RD   = 3'd4;
    localparam t_pc ST_EM_OUT  = 3'd5;
    localparam t_pc ST_DONE    = 3'd6;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_DEC,
        IDX_INC,
        IDX_CLR
    } t_idx_op;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_NZ,
        JMP_IF_NOT_LAST,
        JMP_ON_CLOSE
    } t_jump;

    typedef struct packed {
        logic    load;     // take element beats, busy low
        logic    rd_val;   // read element store at index
        logic    suf_mul;  // acc times element, write suffix store
        logic    rd_emit;  // read prefix at index-1 and suffix at index+1
        logic    emit;     // multiply neighbours, drive a result beat
        logic    done;     // close the vector
        t_idx_op idx_op;
        t_jump   jump;
        t_pc     target;
    } t_ucode;

    function automatic t_ucode ucode(input t_pc pc);
        t_ucode cw;
        cw = '{load: 1'b0, rd_val: 1'b0, suf_mul: 1'b0, rd_emit: 1'b0, emit: 1'b0,
               done: 1'b0, idx_op: IDX_HOLD, jump: JMP_NEXT, target: ST_LOAD};
        unique case (pc)
            ST_LOAD: begin
                cw.load = 1'b1;
                cw.jump = JMP_ON_CLOSE;
            end
            ST_SUF_RD: begin
                cw.rd_val = 1'b1;
            end
            ST_SUF_MUL: begin
                cw.suf_mul = 1'b1;
                cw.idx_op  = IDX_DEC;
                cw.jump    = JMP_IF_NZ;
                cw.target  = ST_SUF_RD;
            end
            ST_EM_SET: begin
                cw.idx_op = IDX_CLR;
            end
            ST_EM_RD: begin
                cw.rd_emit = 1'b1;
            end
            ST_EM_OUT: begin
                cw.emit   = 1'b1;
                cw.idx_op = IDX_INC;
                cw.jump   = JMP_IF_NOT_LAST;
                cw.target = ST_EM_RD;
            end
            ST_DONE: begin
                cw.done   = 1'b1;
                cw.jump   = JMP_ALWAYS;
                cw.target = ST_LOAD;
            end
            default: begin
                cw.jump   = JMP_ALWAYS;
                cw.target = ST_LOAD;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/product_except_self.sv =====
// product_except_self: microcoded sequencer over one shared multiplier and three stores
// depends on rtl/core/pes_pkg.sv (control store, step addresses, field widths)
`default_nettype none

// usage
//   input beats: an element (i_elem_value, i_elem_last) is taken at a rising edge
//   with start high and busy low. busy is low only in the load step, so element
//   beats may follow each other in every cycle while a vector is loaded
//   a vector closes on an element with i_elem_last set, or on the element that
//   fills the last of MAX_LEN slots; busy rises in the cycle after that beat
//   results: one beat per element in index order, each on o_product_out and
//   o_out_last for exactly one cycle while o_strobe is high; o_out_last marks
//   the result for the final index. the receiver cannot hold results off
//   steps for a vector of n elements
//   - load: one multiply per element for the running prefix
//   - suffix pass: two steps per element (store read, multiply), index n-1 down to 0
//   - emission: one setup step, then two steps per result (two store reads,
//     multiply), index 0 up to n-1
//   - busy stays high from the suffix pass to the done step; the control program
//     loops in two steps around the single multiplier and registered store reads
//   reset: synchronous, active low; returns to the load step with an empty
//   vector and a running product of one. the stores keep their contents and
//   are only used at entries written for the current vector
module product_except_self #(
    parameter int unsigned MAX_LEN    = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [DATA_WIDTH-1:0]         i_elem_value,
    input  wire logic                          i_elem_last,
    output logic                               o_strobe,
    output logic [pes_pkg::OUT_W-1:0]          o_product_out,
    output logic                               o_out_last
);

    // index and count widths; the count reaches MAX_LEN itself
    localparam int unsigned IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned CW    = $clog2(MAX_LEN + 1);
    localparam int unsigned DEPTH = 2 ** IW;

    // control state
    pes_pkg::t_pc              r_pc, n_pc;
    logic [IW-1:0]             r_idx, n_idx;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [DATA_WIDTH-1:0]     r_acc, n_acc;
    logic                      r_first, r_lastf;

    // stores and their registered read data
    logic [DATA_WIDTH-1:0]     val_mem [DEPTH];
    logic [DATA_WIDTH-1:0]     pre_mem [DEPTH];
    logic [DATA_WIDTH-1:0]     suf_mem [DEPTH];
    logic [DATA_WIDTH-1:0]     r_val_rd, r_pre_rd, r_suf_rd;

    pes_pkg::t_ucode           cw;
    logic                      accept;
    logic                      close_vec;
    logic [CW-1:0]             cnt_inc;
    logic [CW-1:0]             idx_inc;
    logic [DATA_WIDTH-1:0]     mul_a, mul_b, mul_lo;
    logic [DATA_WIDTH-1:0]     left_nb, after;

    assign cw     = pes_pkg::ucode(r_pc);
    assign busy   = ~cw.load;
    assign accept = start & cw.load;

    assign cnt_inc   = r_cnt + CW'(1);
    assign close_vec = i_elem_last | (cnt_inc == CW'(MAX_LEN));
    assign idx_inc   = CW'(r_idx) + CW'(1);

    // neighbours outside the vector count as one
    assign left_nb = r_first ? DATA_WIDTH'(1) : r_pre_rd;
    assign after   = r_lastf ? DATA_WIDTH'(1) : r_suf_rd;

    // shared multiplier, low half only (wraps)
    always_comb begin
        mul_a = r_acc;
        mul_b = i_elem_value;
        if (cw.suf_mul) begin
            mul_b = r_val_rd;
        end else if (cw.emit) begin
            mul_a = left_nb;
            mul_b = after;
        end
    end
    assign mul_lo = mul_a * mul_b;

    // sequencer next state
    always_comb begin
        n_pc  = r_pc;
        n_idx = r_idx;
        n_cnt = r_cnt;
        n_acc = r_acc;

        case (cw.idx_op)
            pes_pkg::IDX_DEC:  n_idx = r_idx - IW'(1);
            pes_pkg::IDX_INC:  n_idx = r_idx + IW'(1);
            pes_pkg::IDX_CLR:  n_idx = '0;
            default:           n_idx = r_idx;
        endcase

        if (accept) begin
            n_cnt = cnt_inc;
            if (close_vec) begin
                n_idx = r_cnt[IW-1:0];
                n_acc = DATA_WIDTH'(1);
            end else begin
                n_acc = mul_lo;
            end
        end
        if (cw.suf_mul) begin
            n_acc = mul_lo;
        end
        if (cw.done) begin
            n_cnt = '0;
            n_acc = DATA_WIDTH'(1);
        end

        case (cw.jump)
            pes_pkg::JMP_ALWAYS:      n_pc = cw.target;
            pes_pkg::JMP_IF_NZ:       n_pc = (r_idx != '0) ? cw.target : r_pc + 3'd1;
            pes_pkg::JMP_IF_NOT_LAST: n_pc = (!r_lastf) ? cw.target : r_pc + 3'd1;
            pes_pkg::JMP_ON_CLOSE:    n_pc = (accept && close_vec) ? r_pc + 3'd1 : r_pc;
            default:                  n_pc = r_pc + 3'd1;
        endcase
    end

    // sequencer state and registered result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= pes_pkg::ST_LOAD;
            r_idx      <= '0;
            r_cnt      <= '0;
            r_acc      <= DATA_WIDTH'(1);
            o_strobe   <= 1'b0;
            o_out_last <= 1'b0;
        end else begin
            r_pc       <= n_pc;
            r_idx      <= n_idx;
            r_cnt      <= n_cnt;
            r_acc      <= n_acc;
            o_strobe   <= cw.emit;
            o_out_last <= cw.emit & r_lastf;
        end
    end

    // result payload and edge flags
    always_ff @(posedge i_clk) begin
        if (cw.emit) begin
            o_product_out <= pes_pkg::OUT_W'(mul_lo);
        end
        if (cw.rd_emit) begin
            r_first <= (r_idx == '0);
            r_lastf <= (idx_inc == r_cnt);
        end
    end

    // element and prefix stores, written on each element beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            val_mem[r_cnt[IW-1:0]] <= i_elem_value;
            pre_mem[r_cnt[IW-1:0]] <= mul_lo;
        end
        if (cw.rd_val) begin
            r_val_rd <= val_mem[r_idx];
        end
        if (cw.rd_emit) begin
            r_pre_rd <= pre_mem[r_idx - IW'(1)];
        end
    end

    // suffix store, written during the suffix pass
    always_ff @(posedge i_clk) begin
        if (cw.suf_mul) begin
            suf_mem[r_idx] <= mul_lo;
        end
        if (cw.rd_emit) begin
            r_suf_rd <= suf_mem[r_idx + IW'(1)];
        end
    end

`ifndef SYNTHESIS
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result beat while taking elements");

    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_last |-> o_strobe)
        else $error("last mark without a result beat");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result beats in adjacent cycles");

    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_elem_last) |=> busy)
        else $error("vector closed but still taking elements");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_LEN))
        else $error("element count beyond store depth");
`endif

endmodule

`default_nettype wire

// ===== test/tb_product_except_self.sv =====
// tb_product_except_self: self-checking bench for the product-except-self block
// depends on rtl/core/pes_pkg.sv (OUT_W) and rtl/core/product_except_self.sv
`timescale 1ns / 100ps

module tb_product_except_self;

    localparam int unsigned VEC_MAX = 64;
    localparam int unsigned ELEM_W  = 32;
    // settle window for stray beats after the drain, with margin over the busy stretch of a full vector
    localparam int unsigned SETTLE_CYCLES = 300;
    localparam int unsigned DRAIN_LIMIT   = 20000;

    // one expected result beat
    typedef struct {
        logic [pes_pkg::OUT_W-1:0] product;
        logic                      last;
    } t_product_beat;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [ELEM_W-1:0]         i_elem_value;
    logic                      i_elem_last;
    logic                      o_strobe;
    logic [pes_pkg::OUT_W-1:0] o_product_out;
    logic                      o_out_last;

    // elements of the vector being loaded, and results still owed by the block
    logic [ELEM_W-1:0] vector_elems[$];
    t_product_beat     pending_products[$];

    int  mismatch_count  = 0;
    int  elems_sent      = 0;
    int  vectors_closed  = 0;
    int  products_seen   = 0;
    bit  gaps_on         = 1'b1;

    product_except_self #(
        .MAX_LEN    (VEC_MAX),
        .DATA_WIDTH (ELEM_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_elem_value  (i_elem_value),
        .i_elem_last   (i_elem_last),
        .o_strobe      (o_strobe),
        .o_product_out (o_product_out),
        .o_out_last    (o_out_last)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #5ms;
        $display("timeout: %0d result beats still owed", pending_products.size());
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // vector closed: prefix products forwards, suffix products backwards, then
    // each result is the product of its two neighbours, all wrapped to 32 bits
    function automatic void predict_products();
        int                n;
        logic [ELEM_W-1:0] prefix[VEC_MAX];
        logic [ELEM_W-1:0] suffix[VEC_MAX];
        logic [ELEM_W-1:0] acc;
        logic [ELEM_W-1:0] left_part;
        logic [ELEM_W-1:0] right_part;
        t_product_beat     beat;
        n   = vector_elems.size();
        acc = 32'd1;
        for (int i = 0; i < n; i++) begin
            acc       = acc * vector_elems[i];
            prefix[i] = acc;
        end
        acc = 32'd1;
        for (int i = n - 1; i >= 0; i--) begin
            acc       = acc * vector_elems[i];
            suffix[i] = acc;
        end
        for (int i = 0; i < n; i++) begin
            left_part    = (i > 0) ? prefix[i-1] : 32'd1;
            right_part   = (i + 1 < n) ? suffix[i+1] : 32'd1;
            beat.product = left_part * right_part;
            beat.last    = (i == n - 1);
            pending_products = {pending_products, beat};
        end
        vector_elems.delete();
        vectors_closed++;
    endfunction

    // a full store closes the vector even without the last flag
    function automatic void record_element(input logic [ELEM_W-1:0] value,
                                           input logic last);
        vector_elems = {vector_elems, value};
        elems_sent++;
        if (last || vector_elems.size() == VEC_MAX) begin
            predict_products();
        end
    endfunction

    // mostly back-to-back, sometimes a short pause, rarely a long one
    task automatic idle_gap();
        int pick;
        int gap;
        if (!gaps_on) begin
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            gap = 0;
        end else if (pick < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one element beat: drive at the falling edge, wait for an edge with busy low;
    // start is left high so the next beat can follow in the very next cycle
    task automatic send_elem(input logic [ELEM_W-1:0] value, input logic last);
        @(negedge i_clk);
        start        = 1'b1;
        i_elem_value = value;
        i_elem_last  = last;
        do begin
            @(posedge i_clk);
        end while (busy);
        record_element(value, last);
        idle_gap();
    endtask

    // drop start so nothing further is taken between tests
    task automatic stop_sending();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // random element: plain random words with a share of small values,
    // powers of two, extremes and zeros so products stay interesting
    function automatic logic [ELEM_W-1:0] rand_elem();
        logic [ELEM_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 6) - 3;
            6:          v = 32'd1 << $urandom_range(0, 31);
            7: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 32'hffff_ffff;
                    default: v = 32'd1;
                endcase
            end
            8:          v = 32'd0;
            default:    v = $urandom_range(1, 1000);
        endcase
        return v;
    endfunction

    task automatic send_random_vector(input int len);
        for (int i = 0; i < len; i++) begin
            send_elem(rand_elem(), i == len - 1);
        end
    endtask

    // result side: every strobe is a beat, compared with the oldest expectation
    always @(posedge i_clk) begin
        t_product_beat want;
        if (i_rst_n && o_strobe) begin
            products_seen++;
            if (pending_products.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat product=%h last=%b",
                                          o_product_out, o_out_last));
            end else begin
                want = pending_products.pop_front();
                if (o_product_out !== want.product) begin
                    report_mismatch($sformatf("product_out got %h want %h",
                                              o_product_out, want.product));
                end
                if (o_out_last !== want.last) begin
                    report_mismatch($sformatf("out_last got %b want %b",
                                              o_out_last, want.last));
                end
            end
        end
    end

    // one-element vectors always give 1, whatever the element
    task automatic test_single_element();
        send_elem(32'd0, 1'b1);
        send_elem(32'h8000_0000, 1'b1);
        send_elem(32'hffff_ffff, 1'b1);
        stop_sending();
    endtask

    // most positive, most negative, minus one, one and two in one vector
    task automatic test_field_extremes();
        send_elem(32'h7fff_ffff, 1'b0);
        send_elem(32'h8000_0000, 1'b0);
        send_elem(32'hffff_ffff, 1'b0);
        send_elem(32'd1, 1'b0);
        send_elem(32'd2, 1'b1);
        stop_sending();
    endtask

    // one zero leaves a single non-zero result, two zeros clear everything
    task automatic test_zero_elements();
        send_elem(32'd3, 1'b0);
        send_elem(32'd0, 1'b0);
        send_elem(32'd5, 1'b0);
        send_elem(32'hffff_fffe, 1'b1);
        send_elem(32'd0, 1'b0);
        send_elem(32'd7, 1'b0);
        send_elem(32'd0, 1'b1);
        stop_sending();
    endtask

    // products that overflow and wrap to zero, then two most positive elements
    task automatic test_wraparound();
        send_elem(32'h0001_0000, 1'b0);
        send_elem(32'h0001_0000, 1'b0);
        send_elem(32'd3, 1'b1);
        send_elem(32'h7fff_ffff, 1'b0);
        send_elem(32'h7fff_ffff, 1'b1);
        stop_sending();
    endtask

    // short vectors with random content and random pauses
    task automatic test_random_vectors(input int target);
        int len;
        int goal;
        goal = elems_sent + target;
        while (elems_sent < goal) begin
            if ($urandom_range(0, 4) == 0) begin
                len = $urandom_range(9, 24);
            end else begin
                len = $urandom_range(1, 8);
            end
            send_random_vector(len);
        end
        stop_sending();
    endtask

    // no pauses at all, beats on every free cycle
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        for (int v = 0; v < 6; v++) begin
            send_random_vector($urandom_range(1, 6));
        end
        gaps_on = 1'b1;
        stop_sending();
    endtask

    // a full store closes the vector without the flag, the next beat starts
    // a new one; then a full vector that also carries the flag
    task automatic test_store_full();
        for (int i = 0; i < VEC_MAX; i++) begin
            send_elem(rand_elem(), 1'b0);
        end
        send_random_vector(3);
        send_random_vector(VEC_MAX);
        stop_sending();
    endtask

    initial begin
        int drain;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_elem_value = '0;
        i_elem_last  = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_element();
        test_field_extremes();
        test_zero_elements();
        test_wraparound();
        test_random_vectors(100);
        test_back_to_back();
        test_store_full();
        test_random_vectors(40);

        // let the last vector drain, then a settle window for stray beats
        drain = 0;
        while (pending_products.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_products.size() != 0) begin
            report_mismatch($sformatf("%0d result beats never arrived",
                                      pending_products.size()));
        end

        $display("run covered %0d element beats in %0d vectors", elems_sent, vectors_closed);
        $display("%0d result beats checked, %0d mismatches", products_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pes_pkg.sv
rtl/core/product_except_self.sv
test/tb_product_except_self.sv
